// ===== design/lsf_pkg.sv =====
`timescale 1ns / 1ps

package lsf_pkg;

  localparam int BYTE_W = 8;
  localparam int REG_W = 64;
  localparam int LEN_W = 5;
  localparam int TOT_W = LEN_W + 1;
  localparam int COUNT_W = 32;
  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [BYTE_W-1:0] UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_Z = 8'h5a;
  localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_INVERT = 2'd1,
    MODE_WORD   = 2'd2,
    MODE_NOCASE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_PATTERN_LOW  = 2'd0,
    REG_PATTERN_HIGH = 2'd1,
    REG_PATTERN_LEN  = 2'd2,
    REG_MATCH_MODE   = 2'd3
  } reg_index_t;

  // Settings every cell of the window needs for its compare.
  typedef struct packed {
    mode_t             mode;
    logic [LEN_W-1:0]  eff_len;
  } cell_cfg_t;

  function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= UPPER_A && c <= UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// ===== design/line_substring_filter.sv =====
`timescale 1ns / 1ps

// Fixed-string line filter. Text arrives one byte per request and a request
// with end_of_line set closes the line; that request alone produces a result
// (line_selected and the saturating selected_count), which appears in the
// next cycle in an output register. One request is taken every clock while
// the output is free or being taken: the window is a row of MAX_PATTERN+2
// cells, each holding one recent byte and comparing its input byte (the new
// byte or the one held by the cell before) with its pattern byte; the row's
// results are ANDed into the line hit flag. Configuration writes take effect
// at once and apply to later bytes; the mode at end of line decides selection.
module line_substring_filter #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lsf_pkg::BYTE_W-1:0]      text_byte,
  input  logic                            end_of_line,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            line_selected,
  output logic [lsf_pkg::COUNT_W-1:0]     selected_count,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [lsf_pkg::REG_W-1:0]       cfg_data
);

  localparam int DEPTH = MAX_PATTERN + 2;

  logic [lsf_pkg::REG_W-1:0]                 pattern_low;
  logic [lsf_pkg::REG_W-1:0]                 pattern_high;
  logic [lsf_pkg::LEN_W-1:0]                 pattern_length;
  lsf_pkg::mode_t                            match_mode;
  logic [lsf_pkg::LEN_W-1:0]                 eff_len;
  lsf_pkg::cell_cfg_t                        cell_cfg;
  logic [MAX_PATTERN-1:0][lsf_pkg::BYTE_W-1:0] pattern;

  logic [DEPTH:0][lsf_pkg::BYTE_W-1:0]       chain_byte;
  logic [DEPTH:0]                            chain_valid;
  logic [DEPTH-1:0]                          cell_ok;

  logic                                      accept;
  logic                                      shift;
  logic                                      line_end;
  logic                                      line_hit;
  logic                                      final_hit;
  logic                                      sel;
  logic [lsf_pkg::COUNT_W-1:0]               selected_total;
  logic [lsf_pkg::COUNT_W-1:0]               selected_total_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= lsf_pkg::LEN_W'(1);
      match_mode     <= lsf_pkg::MODE_PLAIN;
    end else if (cfg_we) begin
      unique case (lsf_pkg::reg_index_t'(cfg_index))
        lsf_pkg::REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        lsf_pkg::REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        lsf_pkg::REG_PATTERN_LEN:  pattern_length <= cfg_data[lsf_pkg::LEN_W-1:0];
        lsf_pkg::REG_MATCH_MODE:   match_mode     <= lsf_pkg::mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    if (lsf_pkg::TOT_W'(pattern_length) > lsf_pkg::TOT_W'(MAX_PATTERN)) begin
      eff_len = lsf_pkg::LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = pattern_length;
    end
    cell_cfg.mode    = match_mode;
    cell_cfg.eff_len = eff_len;
  end

  // Pattern bytes beyond the two registers read as zero.
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_pat
    if (j < 8) begin : g_low
      assign pattern[j] = pattern_low[8*j +: 8];
    end else if (j < 16) begin : g_high
      assign pattern[j] = pattern_high[8*(j-8) +: 8];
    end else begin : g_zero
      assign pattern[j] = '0;
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign shift    = accept && !end_of_line;
  assign line_end = accept && end_of_line;

  assign chain_byte[0]  = text_byte;
  assign chain_valid[0] = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    lsf_cell #(
      .POS         (i),
      .MAX_PATTERN (MAX_PATTERN)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (shift),
      .clear     (line_end),
      .cfg       (cell_cfg),
      .pattern   (pattern),
      .byte_in   (chain_byte[i]),
      .valid_in  (chain_valid[i]),
      .byte_out  (chain_byte[i+1]),
      .valid_out (chain_valid[i+1]),
      .ok        (cell_ok[i])
    );
  end

  // The empty pattern is found in every line, even an empty one, except in
  // whole word mode.
  always_comb begin
    final_hit = line_hit ||
                ((eff_len == '0) && (match_mode != lsf_pkg::MODE_WORD));
    sel = (match_mode == lsf_pkg::MODE_INVERT) ? !final_hit : final_hit;
    selected_total_next = selected_total;
    if (sel && (selected_total != {lsf_pkg::COUNT_W{1'b1}})) begin
      selected_total_next = selected_total + lsf_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_hit       <= 1'b0;
      selected_total <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (line_end) begin
        line_hit       <= 1'b0;
        selected_total <= selected_total_next;
      end else if (shift && (&cell_ok)) begin
        line_hit <= 1'b1;
      end
      if (line_end) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (line_end) begin
      line_selected  <= sel;
      selected_count <= selected_total_next;
    end
  end

endmodule

// ===== design/lsf_cell.sv =====
`timescale 1ns / 1ps

module lsf_cell #(
  parameter int POS = 0,
  parameter int MAX_PATTERN = 16
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        shift,
  input  logic                                        clear,
  input  lsf_pkg::cell_cfg_t                          cfg,
  input  logic [MAX_PATTERN-1:0][lsf_pkg::BYTE_W-1:0] pattern,
  input  logic [lsf_pkg::BYTE_W-1:0]                  byte_in,
  input  logic                                        valid_in,
  output logic [lsf_pkg::BYTE_W-1:0]                  byte_out,
  output logic                                        valid_out,
  output logic                                        ok
);

  localparam logic [lsf_pkg::TOT_W-1:0] POS_T = lsf_pkg::TOT_W'(POS);

  logic                          word;
  logic                          nocase;
  logic [lsf_pkg::TOT_W-1:0]     total;
  logic [lsf_pkg::TOT_W-1:0]     want_idx;
  logic                          in_use;
  logic                          frame_pos;
  logic [lsf_pkg::BYTE_W-1:0]    pat_sel;
  logic [lsf_pkg::BYTE_W-1:0]    want;
  logic                          same;
  logic [lsf_pkg::BYTE_W-1:0]    byte_q;
  logic                          valid_q;

  assign word   = (cfg.mode == lsf_pkg::MODE_WORD);
  assign nocase = (cfg.mode == lsf_pkg::MODE_NOCASE);

  // Position 0 compares the newest byte, so it lines up with the last element
  // of the compared sequence.
  always_comb begin
    total    = word ? lsf_pkg::TOT_W'(cfg.eff_len) + lsf_pkg::TOT_W'(2)
                    : lsf_pkg::TOT_W'(cfg.eff_len);
    in_use   = POS_T < total;
    want_idx = word ? lsf_pkg::TOT_W'(cfg.eff_len) - POS_T
                    : lsf_pkg::TOT_W'(cfg.eff_len) - POS_T - lsf_pkg::TOT_W'(1);
    frame_pos = word && ((POS == 0) || (POS_T == total - lsf_pkg::TOT_W'(1)));
    pat_sel = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (want_idx == lsf_pkg::TOT_W'(j)) begin
        pat_sel = pattern[j];
      end
    end
    want = frame_pos ? lsf_pkg::SPACE_CHAR : pat_sel;
    same = nocase ? (lsf_pkg::fold(want) == lsf_pkg::fold(byte_in)) : (want == byte_in);
    ok   = !in_use || (valid_in && same);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (clear) begin
      valid_q <= 1'b0;
    end else if (shift) begin
      valid_q <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      byte_q <= byte_in;
    end
  end

  assign byte_out  = byte_q;
  assign valid_out = valid_q;

endmodule
